FILE: rtl/fixed_row_key_binary_search_top_assert.svh
// assertion macros used by the checker file of the row key search block
`ifndef FIXED_ROW_KEY_BINARY_SEARCH_TOP_ASSERT_SVH
`define FIXED_ROW_KEY_BINARY_SEARCH_TOP_ASSERT_SVH

// consequence must hold in the cycle after the antecedent
`define FRKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frks check failed: next-cycle rule");

// consequence must hold in the same cycle as the antecedent
`define FRKS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frks check failed: same-cycle rule");

`endif

FILE: rtl/frks_pkg.sv
// shared constants, widths and helpers of the row key search block
package frks_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ROW_BYTES   = 8;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  // bound sums carry one extra bit
  localparam int SUM_W       = CNT_W + 1;

  // field widths fixed by the interface
  localparam int ROW_W    = 64;
  localparam int IDX_W    = 10;
  localparam int POS_W    = 10;
  localparam int ECNT_W   = 11;
  localparam int KLEN_W   = 4;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;

  // item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // register word index (paddr bit 2)
  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_KEY_LENGTH  = 1'b1;

  // keep only the first ROW_BYTES bytes of a row
  function automatic logic [ROW_W-1:0] row_mask();
    logic [ROW_W-1:0] m;
    m = '1;
    for (int i = ROW_BYTES; i < 8; i++) begin
      m[ROW_W-1-8*i -: 8] = 8'h00;
    end
    return m;
  endfunction

endpackage

FILE: rtl/frks_in_if.sv
// input item channel of the row key search block
interface frks_in_if;
  import frks_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [IDX_W-1:0]  row_index;
  logic [ROW_W-1:0]  row_bytes;
  logic [ROW_W-1:0]  search_key;

  modport source (output valid, kind, row_index, row_bytes, search_key, input ready);
  modport sink   (input valid, kind, row_index, row_bytes, search_key, output ready);
endinterface

FILE: rtl/frks_out_if.sv
// result channel of the row key search block
interface frks_out_if;
  import frks_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [POS_W-1:0]  position;
  logic [ROW_W-1:0]  entry_row;

  modport source (output valid, found, position, entry_row, input ready);
  modport sink   (input valid, found, position, entry_row, output ready);
endinterface

FILE: rtl/frks_ram.sv
// generic single-port-write, single-port-read ram with registered read
module frks_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/fixed_row_key_binary_search_top.sv
// top level of the row key search block: table ram, probe sequencer, config regs
//
//   channel   dir   handshake                 payload
//   in_if     in    valid / ready             kind, row_index, row_bytes, search_key
//   out_if    out   valid / ready             found, position, entry_row
//   apb       in    psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// a write beat completes on acceptance and the block stays ready for the next item
// a search makes P probes (at most clog2(depth)+1, 11 for 1024 rows)
// each probe is one registered ram read plus the byte compare, feeding the next address
// a search with no rows in use answers a miss without a ram read; a stalled result holds the prober
// reset clears control state only; table rows are undefined until written
module fixed_row_key_binary_search_top (
  input  logic                          clk,
  input  logic                          rst_n,
  frks_in_if.sink                       in_if,
  frks_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frks_pkg::PADDR_W-1:0]  paddr,
  input  logic [frks_pkg::PDATA_W-1:0]  pwdata,
  output logic [frks_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import frks_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_MISS  = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    CMP_EQ = 2'b00,
    CMP_LT = 2'b01,
    CMP_GT = 2'b10
  } cmp_t;

  // strncmp-style compare over the first len bytes
  function automatic cmp_t prefix_cmp(input logic [ROW_W-1:0] key,
                                      input logic [ROW_W-1:0] row,
                                      input logic [KLEN_W-1:0] len);
    cmp_t       res;
    logic       done;
    logic [7:0] kb;
    logic [7:0] rb;
    res  = CMP_EQ;
    done = 1'b0;
    for (int i = 0; i < ROW_BYTES; i++) begin
      kb = key[ROW_W-1-8*i -: 8];
      rb = row[ROW_W-1-8*i -: 8];
      if (!done && (KLEN_W'(i) < len)) begin
        if (kb != rb) begin
          res  = (kb < rb) ? CMP_LT : CMP_GT;
          done = 1'b1;
        end else if (kb == 8'h00) begin
          done = 1'b1;
        end
      end
    end
    return res;
  endfunction

  state_t             state_r, state_nxt;
  logic [ECNT_W-1:0]  entry_count_r, entry_count_nxt;
  logic [KLEN_W-1:0]  key_length_r, key_length_nxt;
  logic [ROW_W-1:0]   key_r, key_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;
  logic [ADDR_W-1:0]  mid_r, mid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               found_r, found_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;

  logic               in_accept;
  logic               cfg_write;
  logic               out_free;
  logic [CNT_W-1:0]   n_eff;
  logic [KLEN_W-1:0]  len_eff;
  logic [ADDR_W-1:0]  first_mid;
  cmp_t               cmp;
  logic [CNT_W-1:0]   lo_n;
  logic [CNT_W-1:0]   hi_n;
  logic               go_on;
  logic               hit;
  logic               finish;
  logic [ADDR_W-1:0]  next_mid;
  logic               wr_en;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ROW_W-1:0]   rd_data;

  // handshakes
  assign in_if.ready = (state_r == S_IDLE);
  assign in_accept   = in_if.valid & in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign pready      = 1'b1;
  assign cfg_write   = psel & penable & pwrite & pready;

  // config register writes and reads
  always_comb begin
    entry_count_nxt = entry_count_r;
    key_length_nxt  = key_length_r;
    if (cfg_write) begin
      unique case (paddr[2])
        REG_ENTRY_COUNT: entry_count_nxt = pwdata[ECNT_W-1:0];
        REG_KEY_LENGTH:  key_length_nxt  = pwdata[KLEN_W-1:0];
        default:         entry_count_nxt = entry_count_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ENTRY_COUNT: prdata = PDATA_W'(entry_count_r);
      REG_KEY_LENGTH:  prdata = PDATA_W'(key_length_r);
      default:         prdata = '0;
    endcase
  end

  // effective row count and compare length
  assign n_eff   = (int'(entry_count_r) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(entry_count_r);
  assign len_eff = (int'(key_length_r) > ROW_BYTES) ? KLEN_W'(ROW_BYTES) : key_length_r;
  assign first_mid = ADDR_W'((SUM_W'(n_eff) - SUM_W'(1)) >> 1);

  // probe compare and next bounds (hi is exclusive)
  always_comb begin
    cmp  = prefix_cmp(key_r, rd_data, len_eff);
    hit  = (cmp == CMP_EQ);
    lo_n = lo_r;
    hi_n = hi_r;
    if (cmp == CMP_LT) begin
      hi_n = CNT_W'(mid_r);
    end else begin
      lo_n = CNT_W'(mid_r) + CNT_W'(1);
    end
    go_on    = (lo_n < hi_n);
    finish   = hit || !go_on;
    next_mid = ADDR_W'((SUM_W'(lo_n) + SUM_W'(hi_n) - SUM_W'(1)) >> 1);
  end

  // table ram ports
  assign wr_en   = in_accept && (in_if.kind == KIND_WRITE) &&
                   (int'(in_if.row_index) < TABLE_DEPTH);
  assign rd_addr = (state_r == S_IDLE) ? first_mid : next_mid;
  assign rd_en   = ((state_r == S_IDLE) && in_accept && (in_if.kind == KIND_SEARCH) &&
                    (n_eff != '0)) ||
                   ((state_r == S_PROBE) && !finish);

  frks_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(in_if.row_index)),
    .wr_data (in_if.row_bytes & row_mask()),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer and result register
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    row_nxt       = row_r;
    if (rd_en) begin
      mid_nxt = rd_addr;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && (in_if.kind == KIND_SEARCH)) begin
          key_nxt = in_if.search_key;
          lo_nxt  = '0;
          hi_nxt  = n_eff;
          state_nxt = (n_eff == '0) ? S_MISS : S_PROBE;
        end
      end
      S_PROBE: begin
        if (!finish) begin
          lo_nxt = lo_n;
          hi_nxt = hi_n;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          found_nxt     = hit;
          pos_nxt       = hit ? POS_W'(mid_r) : '0;
          row_nxt       = hit ? rd_data : '0;
          state_nxt     = S_IDLE;
        end
      end
      S_MISS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b0;
          pos_nxt       = '0;
          row_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      entry_count_r <= '0;
      key_length_r  <= KLEN_W'(8);
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      entry_count_r <= entry_count_nxt;
      key_length_r  <= key_length_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
    row_r   <= row_nxt;
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.found     = found_r;
  assign out_if.position  = pos_r;
  assign out_if.entry_row = row_r;

endmodule

FILE: rtl/frks_checker.sv
// port-level checks of the row key search block and their bind
`include "fixed_row_key_binary_search_top_assert.svh"

module frks_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_kind,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_found,
  input logic [frks_pkg::POS_W-1:0]  out_position,
  input logic [frks_pkg::ROW_W-1:0]  out_entry_row
);
  import frks_pkg::*;

  // a result beat stays offered until taken
  `FRKS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // a search beat occupies the block for at least the next cycle
  `FRKS_ASSERT_NEXT(a_search_busy, in_valid && in_ready && (in_kind == KIND_SEARCH), !in_ready)

  // a write beat completes at once and frees the input again
  `FRKS_ASSERT_NEXT(a_write_quick, in_valid && in_ready && (in_kind == KIND_WRITE), in_ready)

  // a miss carries zero position and zero row
  `FRKS_ASSERT_NOW(a_miss_zero, out_valid && !out_found,
                   (out_position == '0) && (out_entry_row == '0))

endmodule

bind fixed_row_key_binary_search_top frks_checker u_frks_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .in_kind       (in_if.kind),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_found     (out_if.found),
  .out_position  (out_if.position),
  .out_entry_row (out_if.entry_row)
);
